@@ design/dltq_pkg.sv @@
package dltq_pkg;

	// Depth must stay a power of two: physical slot = head + offset, wrapping.
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;
	localparam int TIME_BITS   = 16;
	localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CNT_BITS-1:0]  CNT_FULL = CNT_BITS'(QUEUE_DEPTH);
	localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic        op;
		logic [7:0]  task_id;
		logic [15:0] delay;
		logic [15:0] period;
	} cmd_word_t;

	typedef struct packed {
		logic       add_accepted;
		logic       expired;
		logic [7:0] expired_id;
	} rsp_word_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [TIME_BITS-1:0] delta;
		logic [TIME_BITS-1:0] period;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_CHK,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PLACE,
		ST_FINISH
	} state_t;

endpackage

@@ design/delta_list_timer_queue_top.sv @@
// Delta-list timer queue, one command word in, one response word out.
// A tick on a non-empty queue that re-arms nothing passes ST_TICK_CHK, then ST_FINISH loads the response register.
// An add walks the stored entries and shifts the later ones up one slot, through the entry RAM
// and one shared subtractor; a re-arming tick does the same walk and shift after the pop.
// One word at a time: cmd_ready is high only when the sequencer is idle.
// arst_n clears the entry count, head pointer, sequencer and response valid; RAM is not cleared.
module delta_list_timer_queue_top
	import dltq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_word_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	// Sequencer and queue bookkeeping
	state_t              state_q, state_d;
	logic [IDX_BITS-1:0] head_q, head_d;     // physical slot of the earliest entry
	logic [CNT_BITS-1:0] count_q, count_d;

	// Insert walk context
	logic [IDX_BITS-1:0]  pos_q, pos_d;      // logical insert position
	logic [IDX_BITS-1:0]  src_q, src_d;      // logical entry being moved up one slot
	logic [TIME_BITS-1:0] rem_q, rem_d;      // remaining delay
	logic [ID_BITS-1:0]   id_q, id_d;
	logic [TIME_BITS-1:0] per_q, per_d;
	rsp_word_t            res_q, res_d;

	// Response register
	logic      out_valid_q;
	rsp_word_t out_q;
	logic      load_out;

	// Entry RAM ports
	logic                ram_we, ram_re;
	logic [IDX_BITS-1:0] ram_wa, ram_ra;
	entry_t              ram_wd, rd_entry;
	logic [$bits(entry_t)-1:0] ram_rd;

	// Shared subtract/compare unit; top bit is the borrow
	logic [TIME_BITS-1:0] sub_a, sub_b;
	logic [TIME_BITS:0]   diff;

	assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
	assign rd_entry = entry_t'(ram_rd);

	dltq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (ram_re),
		.rd_addr (ram_ra),
		.rd_data (ram_rd)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		count_d  = count_q;
		pos_d    = pos_q;
		src_d    = src_q;
		rem_d    = rem_q;
		id_d     = id_q;
		per_d    = per_q;
		res_d    = res_q;
		ram_we   = 1'b0;
		ram_wa   = head_q + pos_q;
		ram_wd   = rd_entry;
		ram_re   = 1'b0;
		ram_ra   = head_q;
		sub_a    = rem_q;
		sub_b    = rd_entry.delta;
		load_out = 1'b0;

		case (state_q)
			ST_IDLE: begin
				// Keep the head entry prefetched so a tick can test it next cycle.
				ram_re = 1'b1;
				ram_ra = head_q;
				if (cmd_valid) begin
					res_d = '0;
					if (cmd.op == OP_TICK) begin
						if (count_q == '0) begin
							state_d = ST_FINISH;
						end else begin
							state_d = ST_TICK_CHK;
						end
					end else begin
						id_d  = cmd.task_id;
						rem_d = cmd.delay;
						per_d = cmd.period;
						pos_d = '0;
						if (count_q == CNT_FULL) begin
							state_d = ST_FINISH;
						end else begin
							res_d.add_accepted = 1'b1;
							state_d            = ST_WALK_RD;
						end
					end
				end
			end

			ST_TICK_CHK: begin
				sub_a = rd_entry.delta;
				sub_b = TIME_ONE;
				if (rd_entry.delta != '0) begin
					ram_we       = 1'b1;
					ram_wa       = head_q;
					ram_wd       = rd_entry;
					ram_wd.delta = diff[TIME_BITS-1:0];
					state_d      = ST_FINISH;
				end else begin
					// Pop: advance head, report, re-arm if periodic.
					head_d             = head_q + IDX_BITS'(1);
					count_d            = count_q - CNT_BITS'(1);
					res_d.expired      = 1'b1;
					res_d.expired_id   = rd_entry.id;
					if (rd_entry.period != '0) begin
						id_d    = rd_entry.id;
						rem_d   = rd_entry.period;
						per_d   = rd_entry.period;
						pos_d   = '0;
						state_d = ST_WALK_RD;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end

			ST_WALK_RD: begin
				if ({1'b0, pos_q} == count_q) begin
					state_d = ST_PLACE;
				end else begin
					ram_re  = 1'b1;
					ram_ra  = head_q + pos_q;
					state_d = ST_WALK_CMP;
				end
			end

			ST_WALK_CMP: begin
				// rem >= delta: pass this entry (equal times go behind it).
				sub_a = rem_q;
				sub_b = rd_entry.delta;
				if (!diff[TIME_BITS]) begin
					rem_d   = diff[TIME_BITS-1:0];
					pos_d   = pos_q + IDX_BITS'(1);
					state_d = ST_WALK_RD;
				end else begin
					src_d   = IDX_BITS'(count_q - CNT_BITS'(1));
					state_d = ST_SHIFT_RD;
				end
			end

			ST_SHIFT_RD: begin
				ram_re  = 1'b1;
				ram_ra  = head_q + src_q;
				state_d = ST_SHIFT_WR;
			end

			ST_SHIFT_WR: begin
				// Move up one slot; the entry that lands behind the new one loses rem.
				sub_a  = rd_entry.delta;
				sub_b  = rem_q;
				ram_we = 1'b1;
				ram_wa = head_q + src_q + IDX_BITS'(1);
				ram_wd = rd_entry;
				if (src_q == pos_q) begin
					ram_wd.delta = diff[TIME_BITS-1:0];
					state_d      = ST_PLACE;
				end else begin
					src_d   = src_q - IDX_BITS'(1);
					state_d = ST_SHIFT_RD;
				end
			end

			ST_PLACE: begin
				ram_we        = 1'b1;
				ram_wa        = head_q + pos_q;
				ram_wd.id     = id_q;
				ram_wd.delta  = rem_q;
				ram_wd.period = per_q;
				count_d       = count_q + CNT_BITS'(1);
				state_d       = ST_FINISH;
			end

			ST_FINISH: begin
				if (!out_valid_q || rsp_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		src_q <= src_d;
		rem_q <= rem_d;
		id_q  <= id_d;
		per_q <= per_d;
		res_q <= res_d;
		if (load_out) begin
			out_q <= res_q;
		end
	end

endmodule

@@ design/dltq_ram.sv @@
module dltq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/dltq_checker.sv @@
module dltq_checker
	import dltq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_ready,
	input cmd_word_t cmd,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_word_t rsp
);

	// A stalled response word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// One command word in flight: ready drops after every accept.
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while busy");

	// A word is either an add result or a tick result.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.add_accepted && rsp.expired))
		else $error("add and expiry in one response");

	// Without an expiry the id reads zero.
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.expired |-> rsp.expired_id == '0)
		else $error("nonzero id without expiry");

endmodule

bind delta_list_timer_queue_top dltq_checker u_dltq_checker (.*);

@@ sim/timer_queue_checker.sv @@
module timer_queue_checker
	import dltq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  cmd_word_t cmd,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_word_t rsp,
	output int        mismatch_count,
	output int        open_words
);

	// Shadow copy of the sorted delta list, head at index 0.
	logic [ID_BITS-1:0]   slot_id     [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] slot_delta  [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] slot_period [QUEUE_DEPTH];
	int unsigned          slot_count = 0;

	rsp_word_t timer_replies[$];

	task automatic note_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Sorted insert; ties land behind entries already due at the same tick.
	function automatic bit enqueue_timer(input logic [ID_BITS-1:0] id,
			input logic [TIME_BITS-1:0] dly, input logic [TIME_BITS-1:0] per);
		int unsigned          pos;
		int unsigned          k;
		logic [TIME_BITS-1:0] left;
		if (slot_count >= QUEUE_DEPTH)
			return 1'b0;
		pos  = 0;
		left = dly;
		while (pos < slot_count && left >= slot_delta[pos]) begin
			left -= slot_delta[pos];
			pos++;
		end
		if (pos < slot_count)
			slot_delta[pos] -= left;
		for (k = slot_count; k > pos; k--) begin
			slot_id[k]     = slot_id[k-1];
			slot_delta[k]  = slot_delta[k-1];
			slot_period[k] = slot_period[k-1];
		end
		slot_id[pos]     = id;
		slot_delta[pos]  = left;
		slot_period[pos] = per;
		slot_count++;
		return 1'b1;
	endfunction

	function automatic rsp_word_t timer_step(input cmd_word_t w);
		rsp_word_t            r;
		logic [ID_BITS-1:0]   id;
		logic [TIME_BITS-1:0] per;
		int unsigned          k;
		r = '0;
		if (w.op == OP_ADD) begin
			r.add_accepted = enqueue_timer(w.task_id, w.delay, w.period);
		end else if (slot_count > 0) begin
			if (slot_delta[0] != '0) begin
				slot_delta[0] = slot_delta[0] - TIME_ONE;
			end else begin
				id  = slot_id[0];
				per = slot_period[0];
				for (k = 1; k < slot_count; k++) begin
					slot_id[k-1]     = slot_id[k];
					slot_delta[k-1]  = slot_delta[k];
					slot_period[k-1] = slot_period[k];
				end
				slot_count--;
				r.expired    = 1'b1;
				r.expired_id = id;
				// pop just freed a slot, so the re-arm always fits
				if (per != '0)
					void'(enqueue_timer(id, per, per));
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			slot_count     = 0;
			mismatch_count = 0;
			timer_replies.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (timer_replies.size() == 0) begin
					note_mismatch("word with nothing pending", rsp, 0);
				end else begin
					want = timer_replies.pop_front();
					if (rsp.add_accepted !== want.add_accepted)
						note_mismatch("add_accepted", rsp.add_accepted, want.add_accepted);
					if (rsp.expired !== want.expired)
						note_mismatch("expired", rsp.expired, want.expired);
					if (rsp.expired_id !== want.expired_id)
						note_mismatch("expired_id", rsp.expired_id, want.expired_id);
				end
			end
			if (cmd_valid && cmd_ready)
				timer_replies.push_back(timer_step(cmd));
		end
		open_words = timer_replies.size();
	end

endmodule

@@ sim/tb_delta_list_timer_queue_top.sv @@
module tb_delta_list_timer_queue_top
	import dltq_pkg::*;
();

	localparam int CLK_PERIOD       = 8;
	localparam int RESET_CYCLES     = 9;
	localparam int RANDOM_WORDS     = 1000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LONG_HOLD_AFTER  = 300;   // words sent before the long receiver hold
	localparam int MID_PAUSE_AFTER  = 500;   // words sent before the mid-run drain pause
	localparam int CALM_AFTER       = 850;   // no idling on either side past this point
	// margin over the slowest add plus re-arm
	localparam int DRAIN_CYCLES     = 100;
	localparam int LIMIT_CYCLES     = 1_000_000;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	cmd_word_t cmd;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_word_t rsp;

	int mismatch_count;
	int open_words;

	// sent_words and calm are shared between the sender and receiver processes
	int unsigned sent_words     = 0;
	bit          calm           = 1'b0;
	bit          long_hold_done = 1'b0;

	delta_list_timer_queue_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	timer_queue_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.open_words     (open_words)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic cmd_word_t timer_add(input logic [7:0] id, input logic [15:0] dly,
			input logic [15:0] per);
		cmd_word_t w;
		w.op      = OP_ADD;
		w.task_id = id;
		w.delay   = dly;
		w.period  = per;
		return w;
	endfunction

	// Tick word; the unused fields carry noise the block must ignore.
	function automatic cmd_word_t timer_tick();
		cmd_word_t w;
		w.op      = OP_TICK;
		w.task_id = 8'($urandom_range(0, 255));
		w.delay   = 16'($urandom_range(0, 65535));
		w.period  = 16'($urandom_range(0, 65535));
		return w;
	endfunction

	// One-shot with a short delay, so ties and front inserts are common.
	function automatic cmd_word_t oneshot_add();
		logic [15:0] dly;
		if ($urandom_range(0, 3) != 0)
			dly = 16'($urandom_range(0, 7));
		else
			dly = 16'($urandom_range(8, 48));
		return timer_add(8'($urandom_range(0, 255)), dly, '0);
	endfunction

	// Fully random add; only sent while the list is known to be full.
	function automatic cmd_word_t wild_add();
		return timer_add(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
	endfunction

	// Offer one word at the falling edge and hold it until the handshake.
	task automatic offer_word(input cmd_word_t w);
		int unsigned gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= w;
		do
			@(posedge clk);
		while (!cmd_ready);
		sent_words++;
	endtask

	// Stop sending and let every pending response come back.
	task automatic wait_quiet();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (open_words != 0)
			@(negedge clk);
	endtask

	// Receiver: random stall bursts, plus one long hold so the block backs up.
	initial begin
		int unsigned stall_len;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && !long_hold_done && sent_words >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_len = $urandom_range(1, 8);
				rsp_ready <= 1'b0;
				repeat (stall_len - 1) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Sender and verdict.
	initial begin
		int unsigned target;
		int unsigned pick;
		int unsigned run_len;
		int unsigned periodic_left;
		bit          mid_pause_done;

		arst_n         = 1'b0;
		cmd_valid      = 1'b0;
		cmd            = '0;
		periodic_left  = 6;
		mid_pause_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty tick, zero delay, largest fields, ties, front insert,
		// periodic add, then fill past the top so at least one add bounces.
		offer_word(timer_tick());
		offer_word(timer_add(8'h00, 16'd0, 16'd0));
		offer_word(timer_tick());
		offer_word(timer_add(8'hFF, 16'hFFFF, 16'hFFFF));
		offer_word(timer_add(8'hA5, 16'd3, 16'd2));
		offer_word(timer_add(8'h5A, 16'd3, 16'd0));
		offer_word(timer_add(8'h01, 16'd1, 16'd0));
		repeat (4) offer_word(timer_tick());
		// FF, 5A and the re-arming A5 stay resident, so 15 more adds overflow
		for (int k = 0; k < 15; k++)
			offer_word(timer_add(8'(8'h10 + k), 16'(k % 4), 16'd0));
		wait_quiet();

		target = sent_words + RANDOM_WORDS;
		while (sent_words < target) begin
			if (!mid_pause_done && sent_words >= MID_PAUSE_AFTER) begin
				mid_pause_done = 1'b1;
				wait_quiet();
			end
			if (sent_words >= CALM_AFTER)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				// 16 adds in a row fill the list whatever its state, so the
				// wild adds after them are always bounced
				repeat (16) offer_word(oneshot_add());
				repeat (3) offer_word(wild_add());
			end else if (pick < 9) begin
				run_len = $urandom_range(10, 30);
				repeat (run_len) offer_word(timer_tick());
			end else if (pick < 11 && periodic_left > 0) begin
				// re-arming timers never leave, so only a handful are added
				periodic_left--;
				offer_word(timer_add(8'($urandom_range(0, 255)), 16'($urandom_range(0, 24)),
						16'($urandom_range(1, 24))));
			end else if (pick < 60) begin
				offer_word(timer_tick());
			end else begin
				offer_word(oneshot_add());
			end
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
design/dltq_pkg.sv
design/dltq_ram.sv
design/delta_list_timer_queue_top.sv
design/dltq_checker.sv
sim/timer_queue_checker.sv
sim/tb_delta_list_timer_queue_top.sv
